FILE: rtl/nrmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nrmc_pkg;

  localparam logic [3:0] TIME_COMMA  = 4'd1;
  localparam logic [3:0] DATE_COMMA  = 4'd9;
  localparam logic [3:0] COMMA_MAX   = 4'd15;
  localparam logic [2:0] GROUP_LEN   = 3'd6;
  localparam logic [2:0] POS_PAIR_A  = 3'd1;
  localparam logic [2:0] POS_PAIR_B  = 3'd3;
  localparam logic [4:0] ZONE_RESET  = 5'd8;
  localparam logic [7:0] YEAR_BIAS   = 8'd100;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] HOURS_DAY   = 8'd24;

  typedef struct packed {
    logic [7:0] char_in;
    logic       line_end;
  } in_word_t;

  typedef struct packed {
    logic              parse_ok;
    logic [4:0]        hour_out;
    logic [6:0]        minute_out;
    logic [6:0]        second_out;
    logic [6:0]        day_out;
    logic signed [7:0] month_out;
    logic [7:0]        year_out;
  } out_word_t;

  // tens * 10 + units, both decimal digits
  function automatic logic [6:0] pair_value(input logic [3:0] tens, input logic [3:0] units);
    logic [6:0] t;
    begin
      t = {3'b000, tens};
      pair_value = (t << 3) + (t << 1) + {3'b000, units};
    end
  endfunction

  // reduce a value below 192 modulo 24 by three conditional subtracts
  function automatic logic [4:0] mod_hours(input logic [7:0] x);
    logic [7:0] v;
    begin
      v = x;
      if (v >= (HOURS_DAY << 2)) v = v - (HOURS_DAY << 2);
      if (v >= (HOURS_DAY << 1)) v = v - (HOURS_DAY << 1);
      if (v >= HOURS_DAY) v = v - HOURS_DAY;
      mod_hours = v[4:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/nmea_rmc_time_date_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// RMC time/date field parser. Takes one sentence byte per cycle; the byte
// flagged line_end closes the line and produces one result word carrying
// parse_ok (date group stored, no non-digit in a group) and all stored
// time/date values, registered and shown in the cycle after that byte is
// taken. Each byte is handled in its accept cycle by small digit/comma
// logic feeding the state registers, so the sustained rate is one byte per
// clock. in_stall is raised only while the result register holds a stalled
// word. The zone offset (reset 8) is added to the hour and reduced modulo 24.
module nmea_rmc_time_date_parser
  import nrmc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [4:0] cfg_data
);

  logic [4:0] zone_r;
  logic [3:0] comma_count_r, comma_count_nxt;
  logic [2:0] digit_pos_r, digit_pos_nxt;
  logic [3:0] tens_r, tens_nxt;
  logic       line_failed_r, line_failed_nxt;
  logic       date_done_r, date_done_nxt;
  logic [6:0] stage_a_r, stage_a_nxt;
  logic [6:0] stage_b_r, stage_b_nxt;
  logic [4:0] hour_r, hour_nxt;
  logic [6:0] minute_r, minute_nxt;
  logic [6:0] second_r, second_nxt;
  logic [6:0] day_r, day_nxt;
  logic [7:0] month_r, month_nxt;
  logic [7:0] year_r, year_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_word_r, out_word_nxt;

  logic       in_acc;
  logic       in_group;
  logic       is_digit;
  logic [3:0] digit;
  logic [6:0] pair;

  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign in_group = ((comma_count_r == TIME_COMMA) || (comma_count_r == DATE_COMMA))
                    && (digit_pos_r < GROUP_LEN);
  assign is_digit = (in_word.char_in >= CHAR_ZERO) && (in_word.char_in <= CHAR_NINE);
  assign digit    = in_word.char_in[3:0];
  assign pair     = pair_value(tens_r, digit);

  always_comb begin
    comma_count_nxt = comma_count_r;
    digit_pos_nxt   = digit_pos_r;
    tens_nxt        = tens_r;
    line_failed_nxt = line_failed_r;
    date_done_nxt   = date_done_r;
    stage_a_nxt     = stage_a_r;
    stage_b_nxt     = stage_b_r;
    hour_nxt        = hour_r;
    minute_nxt      = minute_r;
    second_nxt      = second_r;
    day_nxt         = day_r;
    month_nxt       = month_r;
    year_nxt        = year_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_word_nxt    = out_word_r;

    if (in_acc) begin
      if (!line_failed_r) begin
        if (in_group) begin
          if (is_digit) begin
            if (!digit_pos_r[0]) begin
              tens_nxt = digit;
            end else begin
              case (digit_pos_r)
                POS_PAIR_A: stage_a_nxt = pair;
                POS_PAIR_B: stage_b_nxt = pair;
                default: begin
                  if (comma_count_r == TIME_COMMA) begin
                    hour_nxt   = mod_hours({1'b0, stage_a_r} + {3'b000, zone_r});
                    minute_nxt = stage_b_r;
                    second_nxt = pair;
                  end else begin
                    day_nxt       = stage_a_r;
                    month_nxt     = {1'b0, stage_b_r} - 8'd1;
                    year_nxt      = {1'b0, pair} + YEAR_BIAS;
                    date_done_nxt = 1'b1;
                  end
                end
              endcase
            end
            digit_pos_nxt = digit_pos_r + 3'd1;
          end else begin
            line_failed_nxt = 1'b1;
          end
        end else if (in_word.char_in == CHAR_COMMA) begin
          if (comma_count_r != COMMA_MAX) comma_count_nxt = comma_count_r + 4'd1;
          digit_pos_nxt = '0;
        end
      end

      if (in_word.line_end) begin
        out_valid_nxt           = 1'b1;
        out_word_nxt.parse_ok   = date_done_nxt && !line_failed_nxt;
        out_word_nxt.hour_out   = hour_nxt;
        out_word_nxt.minute_out = minute_nxt;
        out_word_nxt.second_out = second_nxt;
        out_word_nxt.day_out    = day_nxt;
        out_word_nxt.month_out  = month_nxt;
        out_word_nxt.year_out   = year_nxt;
        // per-line state starts over; stored values stay
        comma_count_nxt = '0;
        digit_pos_nxt   = '0;
        tens_nxt        = '0;
        line_failed_nxt = 1'b0;
        date_done_nxt   = 1'b0;
        stage_a_nxt     = '0;
        stage_b_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r        <= ZONE_RESET;
      comma_count_r <= '0;
      digit_pos_r   <= '0;
      tens_r        <= '0;
      line_failed_r <= 1'b0;
      date_done_r   <= 1'b0;
      stage_a_r     <= '0;
      stage_b_r     <= '0;
      hour_r        <= '0;
      minute_r      <= '0;
      second_r      <= '0;
      day_r         <= '0;
      month_r       <= '0;
      year_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) zone_r <= cfg_data;
      comma_count_r <= comma_count_nxt;
      digit_pos_r   <= digit_pos_nxt;
      tens_r        <= tens_nxt;
      line_failed_r <= line_failed_nxt;
      date_done_r   <= date_done_nxt;
      stage_a_r     <= stage_a_nxt;
      stage_b_r     <= stage_b_nxt;
      hour_r        <= hour_nxt;
      minute_r      <= minute_nxt;
      second_r      <= second_nxt;
      day_r         <= day_nxt;
      month_r       <= month_nxt;
      year_r        <= year_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
    hour_r < HOURS_DAY[4:0])
    else $error("stored hour out of range");

  a_digit_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    digit_pos_r <= GROUP_LEN)
    else $error("digit position past group length");

  a_line_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_word.line_end |=> out_valid_r)
    else $error("line end word produced no result");

  a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_word.line_end |=>
      (comma_count_r == '0) && (digit_pos_r == '0) && !line_failed_r && !date_done_r)
    else $error("per-line state not cleared after line end");

  a_ok_needs_date: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_word.line_end && !date_done_r && !(in_group && is_digit)
      |=> !out_word_r.parse_ok)
    else $error("parse_ok without a stored date");

endmodule

`default_nettype wire
